FILE: rtl/core/iqs_pkg.sv
// Shared constants for the iterative quicksort block.
// No dependencies; used by iqs_store, iterative_quicksort, iqs_sort_checker and the testbench.
package iqs_pkg;

    // Width of one list element, two's complement.
    localparam int WORD_W = 32;

    // Default capacity of the element store.
    localparam int DEF_MAX_ELEMENTS = 32;

    // Default depth of the range-bound stack.
    localparam int DEF_STACK_DEPTH = 64;

endpackage

FILE: rtl/core/iqs_store.sv
// Element store of the iterative quicksort: one write port, one registered read port.
// Depends on iqs_pkg for the word width and the default depth.
module iqs_store #(
    parameter int DEPTH = iqs_pkg::DEF_MAX_ELEMENTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  logic [iqs_pkg::WORD_W-1:0]     i_wdata,
    input  logic [AW-1:0]                  i_raddr,
    output logic [iqs_pkg::WORD_W-1:0]     o_rdata
);

    logic [iqs_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [iqs_pkg::WORD_W-1:0] r_q;
    logic [iqs_pkg::WORD_W-1:0] r_fwd_data;
    logic                       r_fwd_hit;

    // Storage array with a synchronous read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q        <= r_mem[i_raddr];
        r_fwd_data <= i_wdata;
    end

    // A read that hits the entry written in the same cycle sees the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_fwd_hit ? r_fwd_data : r_q;

endmodule

FILE: rtl/core/iterative_quicksort.sv
// Iterative quicksort: top level with the sort sequencer and the range-bound stack.
// Depends on iqs_pkg and iqs_store.
//
// The block takes one signed value per request until a request marked last_in, holding up to
// MAX_ELEMENTS values; further values are discarded and every result of that list then shows
// dropped. It sorts the list ascending in place and returns one result per stored value, the
// final one marked last_out. Loading accepts one value per cycle. Sorting is bound by the single
// read port of the element store: the partition scans read one element per compare, and each
// popped range also passes through stack pops, pivot fetch and pushes. Each result is read from
// the store and then captured into the output register; the read waits while that register is
// full and stalled. While a list is sorted or emitted, o_stall stays high; a new list may load
// while the final result is still waiting in the output register. No clearing pass follows reset.
module iterative_quicksort #(
    parameter int MAX_ELEMENTS = iqs_pkg::DEF_MAX_ELEMENTS,
    parameter int STACK_DEPTH  = iqs_pkg::DEF_STACK_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [iqs_pkg::WORD_W-1:0] i_value,
    input  logic                              i_last_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [iqs_pkg::WORD_W-1:0] o_sorted_value,
    output logic                              o_last_out,
    output logic                              o_dropped
);

    localparam int IW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int EW = CW + 1;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [12:0] {
        S_LOAD     = 13'b0000000000001,
        S_PUSH_A   = 13'b0000000000010,
        S_PUSH_B   = 13'b0000000000100,
        S_PUSH_C   = 13'b0000000001000,
        S_PUSH_D   = 13'b0000000010000,
        S_POP_HI   = 13'b0000000100000,
        S_POP_LO   = 13'b0000001000000,
        S_FETCH    = 13'b0000010000000,
        S_PIV_WAIT = 13'b0000100000000,
        S_SCAN_R   = 13'b0001000000000,
        S_SCAN_L   = 13'b0010000000000,
        S_EMIT_RD  = 13'b0100000000000,
        S_EMIT_CAP = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [PW-1:0] r_sp, n_sp;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_loc, n_loc;
    logic [IW-1:0] r_piv, n_piv;
    logic [IW-1:0] r_left, n_left;
    logic [IW-1:0] r_right, n_right;
    logic [IW-1:0] r_emit_idx, n_emit_idx;
    logic signed [iqs_pkg::WORD_W-1:0] r_pivot, n_pivot;

    logic                              r_out_valid;
    logic signed [iqs_pkg::WORD_W-1:0] r_out_value;
    logic                              r_out_last;
    logic                              r_out_drop;

    // Element store controls.
    logic                              st_we;
    logic [IW-1:0]                     st_waddr;
    logic [iqs_pkg::WORD_W-1:0]        st_wdata;
    logic [IW-1:0]                     st_raddr;
    logic [iqs_pkg::WORD_W-1:0]        st_rdata;
    logic signed [iqs_pkg::WORD_W-1:0] st_val;

    // Range stack controls.
    logic [IW-1:0] r_stack [STACK_DEPTH];
    logic [IW-1:0] r_stack_q;
    logic          sk_we;
    logic [IW-1:0] sk_wdata;
    logic [SW-1:0] sk_raddr;
    logic [PW-1:0] sp_dec;
    logic          push_ok;

    logic          in_take;
    logic          out_free;
    logic          emit_last;
    logic [CW-1:0] count_new;
    logic [EW-1:0] lo_x, hi_x, loc_x;
    logic          cond_left, cond_right;
    logic [IW-1:0] right_dec, left_inc;

    iqs_store #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign st_val = $signed(st_rdata);

    // Handshake and helper terms.
    assign o_stall   = (r_state != S_LOAD);
    assign in_take   = i_valid && (r_state == S_LOAD);
    assign out_free  = !r_out_valid || !i_stall;
    assign emit_last = ((CW'(r_emit_idx) + CW'(1)) == r_count);
    assign count_new = (r_count < CW'(MAX_ELEMENTS)) ? r_count + CW'(1) : r_count;
    assign sp_dec    = r_sp - PW'(1);
    assign push_ok   = (r_sp < PW'(STACK_DEPTH));
    assign lo_x      = EW'(r_lo);
    assign hi_x      = EW'(r_hi);
    assign loc_x     = EW'(r_loc);
    assign cond_left  = (loc_x >= lo_x + EW'(2));
    assign cond_right = (hi_x >= loc_x + EW'(2));
    assign right_dec = r_right - IW'(1);
    assign left_inc  = r_left + IW'(1);

    // Sort sequencer.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_sp       = r_sp;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_loc      = r_loc;
        n_piv      = r_piv;
        n_left     = r_left;
        n_right    = r_right;
        n_emit_idx = r_emit_idx;
        n_pivot    = r_pivot;
        st_we      = 1'b0;
        st_waddr   = r_piv;
        st_wdata   = r_pivot;
        st_raddr   = r_emit_idx;
        sk_we      = 1'b0;
        sk_wdata   = r_lo;
        sk_raddr   = sp_dec[SW-1:0];
        case (r_state)
            S_LOAD: begin
                if (in_take) begin
                    if (r_count < CW'(MAX_ELEMENTS)) begin
                        st_we    = 1'b1;
                        st_waddr = r_count[IW-1:0];
                        st_wdata = i_value;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_count = count_new;
                    if (i_last_in) begin
                        // Seed the stack with the whole list as if a pivot sat past its end.
                        n_lo       = '0;
                        n_loc      = count_new;
                        n_hi       = IW'(count_new - CW'(1));
                        n_sp       = '0;
                        n_emit_idx = '0;
                        n_state    = S_PUSH_A;
                    end
                end
            end
            S_PUSH_A: begin
                if (cond_left) begin
                    if (push_ok) begin
                        sk_we    = 1'b1;
                        sk_wdata = r_lo;
                        n_sp     = r_sp + PW'(1);
                    end
                    n_state = S_PUSH_B;
                end else begin
                    n_state = S_PUSH_C;
                end
            end
            S_PUSH_B: begin
                if (push_ok) begin
                    sk_we    = 1'b1;
                    sk_wdata = IW'(r_loc - CW'(1));
                    n_sp     = r_sp + PW'(1);
                end
                n_state = S_PUSH_C;
            end
            S_PUSH_C: begin
                if (cond_right) begin
                    if (push_ok) begin
                        sk_we    = 1'b1;
                        sk_wdata = IW'(r_loc + CW'(1));
                        n_sp     = r_sp + PW'(1);
                    end
                    n_state = S_PUSH_D;
                end else begin
                    n_state = S_POP_HI;
                end
            end
            S_PUSH_D: begin
                if (push_ok) begin
                    sk_we    = 1'b1;
                    sk_wdata = r_hi;
                    n_sp     = r_sp + PW'(1);
                end
                n_state = S_POP_HI;
            end
            S_POP_HI: begin
                // Fewer than two bounds left means the list is sorted.
                if (r_sp < PW'(2)) begin
                    n_sp    = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_sp    = sp_dec;
                    n_state = S_POP_LO;
                end
            end
            S_POP_LO: begin
                n_hi    = r_stack_q;
                n_sp    = sp_dec;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_lo = r_stack_q;
                if (r_stack_q >= r_hi) begin
                    n_state = S_POP_HI;
                end else begin
                    st_raddr = r_stack_q;
                    n_piv    = r_stack_q;
                    n_left   = r_stack_q;
                    n_right  = r_hi;
                    n_state  = S_PIV_WAIT;
                end
            end
            S_PIV_WAIT: begin
                n_pivot  = st_val;
                st_raddr = r_right;
                n_state  = S_SCAN_R;
            end
            S_SCAN_R: begin
                // The pivot slot is a hole; the pivot value lives in r_pivot until it settles.
                if (r_pivot <= st_val) begin
                    n_right = right_dec;
                    if (right_dec == r_piv) begin
                        st_we    = 1'b1;
                        st_waddr = r_piv;
                        st_wdata = r_pivot;
                        n_loc    = CW'(r_piv);
                        n_state  = S_PUSH_A;
                    end else begin
                        st_raddr = right_dec;
                    end
                end else begin
                    st_we    = 1'b1;
                    st_waddr = r_piv;
                    st_wdata = st_val;
                    n_piv    = r_right;
                    st_raddr = r_left;
                    n_state  = S_SCAN_L;
                end
            end
            S_SCAN_L: begin
                if (st_val <= r_pivot) begin
                    n_left = left_inc;
                    if (left_inc == r_piv) begin
                        st_we    = 1'b1;
                        st_waddr = r_piv;
                        st_wdata = r_pivot;
                        n_loc    = CW'(r_piv);
                        n_state  = S_PUSH_A;
                    end else begin
                        st_raddr = left_inc;
                    end
                end else begin
                    st_we    = 1'b1;
                    st_waddr = r_piv;
                    st_wdata = st_val;
                    n_piv    = r_left;
                    st_raddr = r_right;
                    n_state  = S_SCAN_R;
                end
            end
            S_EMIT_RD: begin
                st_raddr = r_emit_idx;
                if (out_free) begin
                    n_state = S_EMIT_CAP;
                end
            end
            S_EMIT_CAP: begin
                if (emit_last) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end else begin
                    n_emit_idx = r_emit_idx + IW'(1);
                    n_state    = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_sp    <= n_sp;
        end
    end

    // Working bounds and the pivot value.
    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_loc      <= n_loc;
        r_piv      <= n_piv;
        r_left     <= n_left;
        r_right    <= n_right;
        r_emit_idx <= n_emit_idx;
        r_pivot    <= n_pivot;
    end

    // Range-bound stack with a synchronous read.
    always_ff @(posedge i_clk) begin
        if (sk_we) begin
            r_stack[r_sp[SW-1:0]] <= sk_wdata;
        end
        r_stack_q <= r_stack[sk_raddr];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT_CAP) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT_CAP) begin
            r_out_value <= st_val;
            r_out_last  <= emit_last;
            r_out_drop  <= r_ovf;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_last_out     = r_out_last;
    assign o_dropped      = r_out_drop;

    // The element count never passes the store capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    // The stack pointer never passes the stack depth.
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= PW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    // During a scan the pivot hole sits at one end of the open window.
    a_scan_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_R || r_state == S_SCAN_L) |->
            ((r_piv == r_left || r_piv == r_right) && r_left < r_right))
        else $error("scan window broken");

    // Capturing the final result presents it and reopens loading.
    a_last_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_CAP && emit_last) |=>
            (o_valid && o_last_out && r_state == S_LOAD && r_count == '0))
        else $error("final result not presented");

    // A result is captured only into an empty output register.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_CAP) |-> !r_out_valid)
        else $error("output register overwritten");

endmodule

FILE: test/iqs_sort_checker.sv
// Checker for the iterative quicksort block: watches both request channels and predicts results.
// Depends on iqs_pkg for the word width and the default store capacity.
`timescale 1ns / 100ps

module iqs_sort_checker #(
    parameter int MAX_ELEMENTS = iqs_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic signed [iqs_pkg::WORD_W-1:0] i_in_value,
    input  logic                              i_in_last,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [iqs_pkg::WORD_W-1:0] i_out_value,
    input  logic                              i_out_last,
    input  logic                              i_out_dropped,
    output int                                o_fail_count,
    output int                                o_pending
);

    typedef struct {
        logic signed [iqs_pkg::WORD_W-1:0] value;
        logic                              last_out;
        logic                              dropped;
    } t_sorted_word;

    // Values of the list now loading, in arrival order.
    logic signed [iqs_pkg::WORD_W-1:0] loaded_vals [MAX_ELEMENTS];
    int                                loaded_count;
    logic                              loaded_overflow;

    // Results still owed by the block, oldest first.
    t_sorted_word sorted_words_q [$];

    // Sorts the loaded list ascending (signed) and queues one result per stored value.
    function automatic void queue_sorted_list();
        int                                i;
        int                                j;
        logic signed [iqs_pkg::WORD_W-1:0] key;
        t_sorted_word                      word;
        for (i = 1; i < loaded_count; i++) begin
            key = loaded_vals[i];
            j = i - 1;
            while (j >= 0 && loaded_vals[j] > key) begin
                loaded_vals[j + 1] = loaded_vals[j];
                j--;
            end
            loaded_vals[j + 1] = key;
        end
        for (i = 0; i < loaded_count; i++) begin
            word.value    = loaded_vals[i];
            word.last_out = (i == loaded_count - 1);
            word.dropped  = loaded_overflow;
            sorted_words_q.push_back(word);
        end
        loaded_count    = 0;
        loaded_overflow = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_sorted_word want;
        if (!i_rst_n) begin
            loaded_count    = 0;
            loaded_overflow = 1'b0;
            sorted_words_q.delete();
            o_fail_count    = 0;
        end else begin
            // Compare a result leaving the block with the oldest expectation.
            if (i_out_valid && !i_out_stall) begin
                if (sorted_words_q.size() == 0) begin
                    $display("%0t: stray result: expected none, got %0d last %0b dropped %0b",
                             $time, i_out_value, i_out_last, i_out_dropped);
                    o_fail_count++;
                end else begin
                    want = sorted_words_q.pop_front();
                    if (i_out_value !== want.value) begin
                        $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                                 $time, want.value, i_out_value);
                        o_fail_count++;
                    end
                    if (i_out_last !== want.last_out) begin
                        $display("%0t: last_out mismatch: expected %0b, got %0b",
                                 $time, want.last_out, i_out_last);
                        o_fail_count++;
                    end
                    if (i_out_dropped !== want.dropped) begin
                        $display("%0t: dropped mismatch: expected %0b, got %0b",
                                 $time, want.dropped, i_out_dropped);
                        o_fail_count++;
                    end
                end
            end

            // Store an accepted value, or note that the store was already full.
            if (i_in_valid && !i_in_stall) begin
                if (loaded_count < MAX_ELEMENTS) begin
                    loaded_vals[loaded_count] = i_in_value;
                    loaded_count++;
                end else begin
                    loaded_overflow = 1'b1;
                end
                if (i_in_last) begin
                    queue_sorted_list();
                end
            end
        end
        o_pending = sorted_words_q.size();
    end

endmodule

FILE: test/iterative_quicksort_tb.sv
// Testbench top for the iterative quicksort block: clock, reset, list stimulus and verdict.
// Depends on iqs_pkg, iterative_quicksort and iqs_sort_checker.
`timescale 1ns / 100ps

module iterative_quicksort_tb;

    localparam int WORD_W      = iqs_pkg::WORD_W;
    localparam int MAX_ELEMS   = iqs_pkg::DEF_MAX_ELEMENTS;
    localparam int ITEM_TARGET = 180;
    localparam int HOLD_CYCLES = 600;

    // How the values of one random list are chosen.
    typedef enum int {
        FILL_WIDE,
        FILL_NARROW,
        FILL_EXTREME,
        FILL_RISING,
        FILL_FALLING
    } t_fill_mode;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [WORD_W-1:0] i_value;
    logic                     i_last_in;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [WORD_W-1:0] o_sorted_value;
    logic                     o_last_out;
    logic                     o_dropped;

    int fail_count;
    int pending_count;
    int sent_count;
    bit hold_off_req;
    bit hold_done;
    bit no_gaps;

    logic signed [WORD_W-1:0] fixed_vals [8];

    iterative_quicksort u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .i_last_in      (i_last_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_dropped      (o_dropped)
    );

    iqs_sort_checker #(
        .MAX_ELEMENTS (MAX_ELEMS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_value    (i_value),
        .i_in_last     (i_last_in),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_value   (o_sorted_value),
        .i_out_last    (o_last_out),
        .i_out_dropped (o_dropped),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("iterative_quicksort test failed");
        $finish;
    end

    // Offers one request and holds it until the block takes it.
    task automatic drive_value(input logic signed [WORD_W-1:0] val, input logic last);
        @(negedge i_clk);
        i_valid   = 1'b1;
        i_value   = val;
        i_last_in = last;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
    endtask

    // Random gap after a request: mostly none, some short, a few long.
    task automatic sender_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid   = 1'b0;
            i_value   = $urandom;
            i_last_in = 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Sends the first n entries of fixed_vals as one list.
    task automatic drive_fixed_list(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            drive_value(fixed_vals[k], k == n - 1);
            sender_gap();
        end
    endtask

    // Sends one list of n values filled according to mode.
    task automatic drive_random_list(input int n, input t_fill_mode mode);
        int                       k;
        logic signed [WORD_W-1:0] base;
        logic signed [WORD_W-1:0] step;
        logic signed [WORD_W-1:0] val;
        base = $urandom;
        step = $urandom_range(1, 1000);
        for (k = 0; k < n; k++) begin
            case (mode)
                FILL_NARROW: begin
                    val = $signed($urandom_range(0, 6)) - 32'sd3;
                end
                FILL_EXTREME: begin
                    case ($urandom_range(0, 4))
                        0: val = 32'sh8000_0000;
                        1: val = 32'sh7FFF_FFFF;
                        2: val = 32'sd0;
                        3: val = -32'sd1;
                        default: val = $urandom;
                    endcase
                end
                FILL_RISING: begin
                    val = base + step * k;
                end
                FILL_FALLING: begin
                    val = base - step * k;
                end
                default: begin
                    val = $urandom;
                end
            endcase
            drive_value(val, k == n - 1);
            sender_gap();
        end
    endtask

    // Receiver: random stall runs, plus one long hold-off when the stimulus asks for it.
    initial begin
        int   r;
        int   len;
        logic level;
        i_stall   = 1'b0;
        hold_done = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                @(negedge i_clk);
                i_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    level = 1'b0;
                    len   = $urandom_range(1, 24);
                end else if (r < 90) begin
                    level = 1'b1;
                    len   = $urandom_range(1, 3);
                end else begin
                    level = 1'b1;
                    len   = $urandom_range(10, 40);
                end
                @(negedge i_clk);
                i_stall = level;
                repeat (len - 1) @(negedge i_clk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int         r;
        int         n;
        int         list_idx;
        t_fill_mode mode;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_value      = '0;
        i_last_in    = 1'b0;
        sent_count   = 0;
        hold_off_req = 1'b0;
        no_gaps      = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // A single-element list at the most negative value.
        fixed_vals[0] = 32'sh8000_0000;
        drive_fixed_list(1);

        // Two elements at both extremes, out of order.
        fixed_vals[0] = 32'sh7FFF_FFFF;
        fixed_vals[1] = 32'sh8000_0000;
        drive_fixed_list(2);

        // Values around zero and the extremes, mixed.
        fixed_vals[0] = 32'sd0;
        fixed_vals[1] = 32'sh7FFF_FFFF;
        fixed_vals[2] = -32'sd1;
        fixed_vals[3] = 32'sh8000_0000;
        fixed_vals[4] = 32'sd1;
        drive_fixed_list(5);

        // All values equal, so every scan runs past elements equal to the pivot.
        no_gaps = 1'b1;
        fixed_vals[0] = 32'sd7;
        fixed_vals[1] = 32'sd7;
        fixed_vals[2] = 32'sd7;
        fixed_vals[3] = 32'sd7;
        drive_fixed_list(4);
        no_gaps = 1'b0;

        // Already in order.
        fixed_vals[0] = -32'sd3;
        fixed_vals[1] = -32'sd2;
        fixed_vals[2] = -32'sd1;
        fixed_vals[3] = 32'sd0;
        fixed_vals[4] = 32'sd1;
        fixed_vals[5] = 32'sd2;
        drive_fixed_list(6);

        // Duplicates among other values.
        fixed_vals[0] = 32'sd3;
        fixed_vals[1] = 32'sd3;
        fixed_vals[2] = -32'sd5;
        fixed_vals[3] = 32'sd3;
        fixed_vals[4] = -32'sd5;
        drive_fixed_list(5);

        // Random lists; the first overflows the store, the second fills it exactly
        // while the receiver holds off so that the block backs up.
        list_idx = 0;
        while (sent_count < ITEM_TARGET) begin
            r    = $urandom_range(0, 99);
            mode = t_fill_mode'($urandom_range(0, 4));
            if (list_idx == 0) begin
                n = MAX_ELEMS + 2;
            end else if (list_idx == 1) begin
                n = MAX_ELEMS;
                hold_off_req = 1'b1;
            end else if (r < 6) begin
                n = $urandom_range(MAX_ELEMS + 1, MAX_ELEMS + 4);
            end else if (r < 14) begin
                n = MAX_ELEMS;
            end else if (r < 22) begin
                n = $urandom_range(20, MAX_ELEMS - 1);
            end else begin
                n = $urandom_range(1, 12);
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            drive_random_list(n, mode);
            list_idx++;
        end
        no_gaps = 1'b0;

        @(negedge i_clk);
        i_valid   = 1'b0;
        i_last_in = 1'b0;

        // Drain every expected result, then watch a while for strays.
        while (pending_count != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("iterative_quicksort test passed");
        end else begin
            $display("iterative_quicksort test failed");
        end
        $finish;
    end

endmodule
